// ===== hw/rtl/sst_pkg.sv =====
// Shared types and codes for the sorted set table.
`default_nettype none
package sst_pkg;

  // Operation codes carried on the input tuser.
  typedef enum logic [2:0] {
    FN_ADD     = 3'd0,
    FN_REMOVE  = 3'd1,
    FN_MEMBER  = 3'd2,
    FN_MIN     = 3'd3,
    FN_MAX     = 3'd4,
    FN_EXT_MIN = 3'd5,
    FN_EXT_MAX = 3'd6,
    FN_NONE    = 3'd7
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // Result flags passed from the sequencer to the output register.
  typedef struct packed {
    logic ok;
    logic full;
  } res_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sorted_set_table.sv =====
// Add, remove and member scan the key store, then shift its tail when a key goes in before
// the end or comes out before the last place. Min, max and extract max read one end word;
// extract min also shifts the rest of the store down. Min, max and the extracts skip the read on an empty set.
// One request is in work at a time, so a new word is taken in the cycle after the result
// leaves the sequencer; the output register lets it be taken while the previous word waits.
// Reset (rst_n, synchronous, low) empties the set and selects unsigned order.
`default_nettype none
module sorted_set_table #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,     // signed_keys
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,      // [31:0] key
  input  wire logic [2:0]  in_tuser,      // [2:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata      // [0] ok, [1] full_res, [33:2] key_out,
                                          // [40:34] count, [47:41] zero
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed_keys_r;
  logic [KEY_WIDTH+31:0] key_ext;
  logic [KEY_WIDTH-1:0] req_key;
  logic res_valid, res_ready;
  sst_pkg::res_flags_t res_flags;
  logic [KEY_WIDTH-1:0] res_key;
  logic [CW-1:0] res_count;
  logic [KEY_WIDTH+31:0] kout_ext;
  logic [CW+6:0] cnt_ext;
  logic rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [KEY_WIDTH-1:0] rd_data, wr_data;
  logic out_valid_r;
  logic [47:0] out_data_r;

  // Key cut or widened to the table width.
  assign key_ext  = {{KEY_WIDTH{1'b0}}, in_tdata};
  assign req_key  = key_ext[KEY_WIDTH-1:0];
  assign kout_ext = {32'd0, res_key};
  assign cnt_ext  = {7'd0, res_count};

  // Order mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_keys_r <= 1'b0;
    end else if (cfg_we) begin
      signed_keys_r <= cfg_wdata;
    end
  end

  sst_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .signed_keys(signed_keys_r),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_func   (in_tuser),
    .req_key    (req_key),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_flags  (res_flags),
    .res_key    (res_key),
    .res_count  (res_count),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  sst_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(KEY_WIDTH),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // Output word register.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= {7'd0, cnt_ext[6:0], kout_ext[31:0], res_flags.full, res_flags.ok};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  // The held count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_count <= CW'(CAPACITY))
    else $error("count above capacity");

  // A refused full add never reports success.
  a_full_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("full and ok together");

  // A returned key implies success.
  a_key_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[33:2] != 32'd0) |-> out_tdata[0])
    else $error("key returned without ok");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/sst_ram.sv =====
// Single-port-write, single-port-read key store with a registered read.
`default_nettype none
module sst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sst_ctrl.sv =====
// Sequencer that reads, scans, shifts and updates the key store as each request needs.
`default_nettype none
module sst_ctrl #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32,
  parameter int AW        = 6,
  parameter int CW        = 7
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   signed_keys,
  input  wire logic                   req_valid,
  output logic                        req_ready,
  input  wire logic [2:0]             req_func,
  input  wire logic [KEY_WIDTH-1:0]   req_key,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output sst_pkg::res_flags_t         res_flags,
  output logic      [KEY_WIDTH-1:0]   res_key,
  output logic      [CW-1:0]          res_count,
  output logic                        rd_en,
  output logic      [AW-1:0]          rd_addr,
  input  wire logic [KEY_WIDTH-1:0]   rd_data,
  output logic                        wr_en,
  output logic      [AW-1:0]          wr_addr,
  output logic      [KEY_WIDTH-1:0]   wr_data
);

  localparam logic [CW-1:0] CapVal = CW'(CAPACITY);
  localparam logic [CW-1:0] One    = CW'(1);

  sst_pkg::state_t state_r, state_nxt;
  sst_pkg::func_t  func_r, func_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [KEY_WIDTH-1:0] kout_r, kout_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pidx_r, pidx_nxt;
  logic [CW-1:0] last_r, last_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] eq_pos_r, eq_pos_nxt;
  logic [CW-1:0] gt_pos_r, gt_pos_nxt;
  logic [CW-1:0] ins_pos;
  logic pend_r, pend_nxt;
  logic go_r, go_nxt;
  logic up_r, up_nxt;
  logic found_r, found_nxt;
  logic gt_seen_r, gt_seen_nxt;
  logic ok_r, ok_nxt;
  logic full_r, full_nxt;
  logic [KEY_WIDTH-1:0] ord_rd, ord_key;
  logic rd_gt;

  // Map keys to an unsigned order: flipping the sign bit gives signed order.
  assign ord_rd  = {rd_data[KEY_WIDTH-1] ^ signed_keys, rd_data[KEY_WIDTH-2:0]};
  assign ord_key = {key_r[KEY_WIDTH-1] ^ signed_keys, key_r[KEY_WIDTH-2:0]};
  assign rd_gt   = ord_rd > ord_key;
  assign ins_pos = gt_seen_r ? gt_pos_r : cnt_r;

  assign res_flags.ok   = ok_r;
  assign res_flags.full = full_r;
  assign res_key        = kout_r;
  assign res_count      = cnt_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sst_pkg::ST_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      go_r    <= go_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    key_r     <= key_nxt;
    kout_r    <= kout_nxt;
    idx_r     <= idx_nxt;
    pidx_r    <= pidx_nxt;
    last_r    <= last_nxt;
    pos_r     <= pos_nxt;
    eq_pos_r  <= eq_pos_nxt;
    gt_pos_r  <= gt_pos_nxt;
    up_r      <= up_nxt;
    found_r   <= found_nxt;
    gt_seen_r <= gt_seen_nxt;
    ok_r      <= ok_nxt;
    full_r    <= full_nxt;
  end

  // Next state and memory accesses.
  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    key_nxt     = key_r;
    kout_nxt    = kout_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    pidx_nxt    = pidx_r;
    last_nxt    = last_r;
    pos_nxt     = pos_r;
    eq_pos_nxt  = eq_pos_r;
    gt_pos_nxt  = gt_pos_r;
    pend_nxt    = pend_r;
    go_nxt      = go_r;
    up_nxt      = up_r;
    found_nxt   = found_r;
    gt_seen_nxt = gt_seen_r;
    ok_nxt      = ok_r;
    full_nxt    = full_r;
    rd_en       = 1'b0;
    rd_addr     = idx_r[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = pidx_r[AW-1:0];
    wr_data     = rd_data;
    req_ready   = (state_r == sst_pkg::ST_IDLE);
    res_valid   = (state_r == sst_pkg::ST_DONE);

    unique case (state_r)
      sst_pkg::ST_IDLE: begin
        if (req_valid) begin
          func_nxt    = sst_pkg::func_t'(req_func);
          key_nxt     = req_key;
          kout_nxt    = '0;
          ok_nxt      = 1'b0;
          full_nxt    = 1'b0;
          found_nxt   = 1'b0;
          gt_seen_nxt = 1'b0;
          idx_nxt     = '0;
          pend_nxt    = 1'b0;
          go_nxt      = 1'b0;
          unique case (sst_pkg::func_t'(req_func))
            sst_pkg::FN_ADD, sst_pkg::FN_REMOVE, sst_pkg::FN_MEMBER: begin
              state_nxt = sst_pkg::ST_SCAN;
            end
            sst_pkg::FN_MIN, sst_pkg::FN_EXT_MIN: begin
              rd_addr   = '0;
              rd_en     = (cnt_r != '0);
              state_nxt = (cnt_r != '0) ? sst_pkg::ST_READ : sst_pkg::ST_DONE;
            end
            sst_pkg::FN_MAX, sst_pkg::FN_EXT_MAX: begin
              rd_addr   = AW'(cnt_r - One);
              rd_en     = (cnt_r != '0);
              state_nxt = (cnt_r != '0) ? sst_pkg::ST_READ : sst_pkg::ST_DONE;
            end
            default: begin
              state_nxt = sst_pkg::ST_DONE;
            end
          endcase
        end
      end

      // The end word has arrived from the store.
      sst_pkg::ST_READ: begin
        kout_nxt  = rd_data;
        ok_nxt    = 1'b1;
        state_nxt = sst_pkg::ST_DONE;
        if (func_r == sst_pkg::FN_EXT_MAX) begin
          cnt_nxt = cnt_r - One;
        end else if (func_r == sst_pkg::FN_EXT_MIN) begin
          if (cnt_r == One) begin
            cnt_nxt = cnt_r - One;
          end else begin
            up_nxt    = 1'b0;
            idx_nxt   = One;
            last_nxt  = cnt_r - One;
            go_nxt    = 1'b1;
            pend_nxt  = 1'b0;
            state_nxt = sst_pkg::ST_SHIFT;
          end
        end
      end

      // Linear scan: one read issued and one word compared per cycle.
      sst_pkg::ST_SCAN: begin
        pend_nxt = (idx_r != cnt_r);
        pidx_nxt = idx_r;
        if (idx_r != cnt_r) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + One;
        end
        if (pend_r) begin
          if (rd_data == key_r) begin
            found_nxt  = 1'b1;
            eq_pos_nxt = pidx_r;
          end
          if (!gt_seen_r && rd_gt) begin
            gt_seen_nxt = 1'b1;
            gt_pos_nxt  = pidx_r;
          end
        end
        if (idx_r == cnt_r && !pend_r) begin
          state_nxt = sst_pkg::ST_DONE;
          priority case (func_r)
            sst_pkg::FN_ADD: begin
              if (found_r) begin
                ok_nxt = 1'b0;
              end else if (cnt_r == CapVal) begin
                full_nxt = 1'b1;
              end else if (ins_pos == cnt_r) begin
                wr_en   = 1'b1;
                wr_addr = cnt_r[AW-1:0];
                wr_data = key_r;
                cnt_nxt = cnt_r + One;
                ok_nxt  = 1'b1;
              end else begin
                pos_nxt   = ins_pos;
                up_nxt    = 1'b1;
                idx_nxt   = cnt_r - One;
                last_nxt  = ins_pos;
                go_nxt    = 1'b1;
                state_nxt = sst_pkg::ST_SHIFT;
              end
            end
            sst_pkg::FN_REMOVE: begin
              if (found_r) begin
                ok_nxt = 1'b1;
                if (eq_pos_r == cnt_r - One) begin
                  cnt_nxt = cnt_r - One;
                end else begin
                  up_nxt    = 1'b0;
                  idx_nxt   = eq_pos_r + One;
                  last_nxt  = cnt_r - One;
                  go_nxt    = 1'b1;
                  state_nxt = sst_pkg::ST_SHIFT;
                end
              end
            end
            sst_pkg::FN_MEMBER: begin
              ok_nxt = found_r;
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end

      // Move words by one place: read one, write the one read last cycle.
      sst_pkg::ST_SHIFT: begin
        pend_nxt = go_r;
        pidx_nxt = idx_r;
        if (go_r) begin
          rd_en = 1'b1;
          if (idx_r == last_r) begin
            go_nxt = 1'b0;
          end else begin
            idx_nxt = up_r ? idx_r - One : idx_r + One;
          end
        end
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = up_r ? AW'(pidx_r + One) : AW'(pidx_r - One);
        end
        if (!go_r && !pend_r) begin
          state_nxt = sst_pkg::ST_DONE;
          if (up_r) begin
            wr_en   = 1'b1;
            wr_addr = pos_r[AW-1:0];
            wr_data = key_r;
            cnt_nxt = cnt_r + One;
            ok_nxt  = 1'b1;
          end else begin
            cnt_nxt = cnt_r - One;
          end
        end
      end

      sst_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = sst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
